// ===== hw/rtl/sliding_window_median_top_macros.svh =====
// Assertion macros of the sliding window median checker.
`ifndef SLIDING_WINDOW_MEDIAN_TOP_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_TOP_MACROS_SVH

// Same-cycle implication, off during reset.
`define SWM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off during reset.
`define SWM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also runs through reset.
`define SWM_ASSERT_NEXT_ANY(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/swm_pkg.sv =====
// Shared types and constants of the sliding window median filter.
package swm_pkg;

  localparam int DEF_MAX_WINDOW   = 64;
  localparam int DEF_SAMPLE_WIDTH = 32;

  localparam int                CFG_W        = 7;
  localparam logic [CFG_W-1:0]  WINDOW_RESET = 7'd3;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_t;

  // Per-transaction controls broadcast to every cell.
  typedef struct packed {
    logic accept;
    logic evict;
    logic load;
    logic shift;
  } ctl_t;

  // Flags a cell shows its neighbors.
  typedef struct packed {
    logic ge;   // at or above the evicted entry
    logic le;   // valid and not above the new sample
    logic lep;  // le of the entry here once the eviction has closed the gap
  } nbr_t;

endpackage

// ===== hw/rtl/swm_sample_if.sv =====
// Input stream channel: one signed sample per transaction.
interface swm_sample_if #(
  parameter int SAMPLE_WIDTH = swm_pkg::DEF_SAMPLE_WIDTH
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ===== hw/rtl/swm_median_if.sv =====
// Output stream channel: one median value per transaction.
interface swm_median_if #(
  parameter int SAMPLE_WIDTH = swm_pkg::DEF_SAMPLE_WIDTH
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] median_value;

  modport source (output valid, output median_value, input ready);
  modport sink   (input valid, input median_value, output ready);
endinterface

// ===== hw/rtl/swm_cell.sv =====
// One slot of the sorted window: sorted entry, delay-line tap and read-out stage.
module swm_cell #(
  parameter int SAMPLE_WIDTH = swm_pkg::DEF_SAMPLE_WIDTH,
  parameter int MAX_WINDOW   = swm_pkg::DEF_MAX_WINDOW,
  parameter int INDEX        = 0
) (
  input  logic                                          clk,
  input  swm_pkg::ctl_t                                 ctl,
  input  logic signed [SAMPLE_WIDTH-1:0]                x,
  input  logic signed [SAMPLE_WIDTH-1:0]                old,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]               fill,
  input  logic [((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1)-1:0] w_last,
  input  swm_pkg::nbr_t                                 left_nbr,
  input  logic signed [SAMPLE_WIDTH-1:0]                left_value,
  input  swm_pkg::nbr_t                                 right_nbr,
  input  logic signed [SAMPLE_WIDTH-1:0]                right_value,
  input  logic signed [SAMPLE_WIDTH-1:0]                right_tap,
  input  logic signed [SAMPLE_WIDTH-1:0]                right_pipe,
  output swm_pkg::nbr_t                                 nbr,
  output logic signed [SAMPLE_WIDTH-1:0]                value,
  output logic signed [SAMPLE_WIDTH-1:0]                tap,
  output logic signed [SAMPLE_WIDTH-1:0]                pipe
);

  localparam int WIN_W = $clog2(MAX_WINDOW+1);
  localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  logic                           valid;
  logic signed [SAMPLE_WIDTH-1:0] gap_value;   // entry here after eviction
  logic signed [SAMPLE_WIDTH-1:0] left_gap;    // entry to the left after eviction
  logic signed [SAMPLE_WIDTH-1:0] value_next;

  assign valid = WIN_W'(INDEX) < fill;

  // Equal values sit oldest first, so the evicted one is the first equal to old.
  assign nbr.ge  = ctl.evict && valid && (value >= old);
  assign nbr.le  = valid && (value <= x);
  assign nbr.lep = nbr.ge ? right_nbr.le : nbr.le;

  assign gap_value = nbr.ge      ? right_value : value;
  assign left_gap  = left_nbr.ge ? value       : left_value;

  always_comb begin
    if (nbr.lep) begin
      value_next = gap_value;
    end else if (left_nbr.lep) begin
      value_next = x;
    end else begin
      value_next = left_gap;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      value <= value_next;
      tap   <= (IDX_W'(INDEX) == w_last) ? x : right_tap;
    end
    if (ctl.load) begin
      pipe <= value_next;
    end else if (ctl.shift) begin
      pipe <= right_pipe;
    end
  end

endmodule

// ===== hw/rtl/sliding_window_median_top.sv =====
// Running median filter: sorted cell chain with a shift-out read column.
//
// Samples enter on the samples channel; once window_size samples have been
// seen since the last write of window_size, each sample yields the lower
// median of the last window_size samples on the medians channel. While the
// window fills, samples are taken back to back. A sample that yields a
// result blocks the next sample until that result is taken or dropped:
// the sorted window updates in the accept cycle, then the read column
// shifts the median down the cell chain one cell per cycle to cell 0,
// where it is held until taken. A window_size of 0 acts as 1 and one above
// MAX_WINDOW acts as MAX_WINDOW; writing it empties the window. No clearing
// pass after reset.
module sliding_window_median_top #(
  parameter int MAX_WINDOW   = swm_pkg::DEF_MAX_WINDOW,
  parameter int SAMPLE_WIDTH = swm_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [swm_pkg::CFG_W-1:0]   cfg_wr_data,
  swm_sample_if.sink                  samples,
  swm_median_if.source                medians
);

  localparam int WIN_W = $clog2(MAX_WINDOW+1);
  localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CMP_W = (WIN_W > swm_pkg::CFG_W) ? WIN_W : swm_pkg::CFG_W;

  logic [swm_pkg::CFG_W-1:0] window_size;
  logic [WIN_W-1:0]          fill;
  logic [IDX_W-1:0]          cnt;
  swm_pkg::state_t           state, state_next;

  logic [WIN_W-1:0] w_eff;
  logic [IDX_W-1:0] w_last;
  logic [IDX_W-1:0] mid;
  logic             has_result;
  swm_pkg::ctl_t    ctl;

  swm_pkg::nbr_t                  nbrs  [MAX_WINDOW];
  logic signed [SAMPLE_WIDTH-1:0] vals  [MAX_WINDOW];
  logic signed [SAMPLE_WIDTH-1:0] taps  [MAX_WINDOW];
  logic signed [SAMPLE_WIDTH-1:0] pipes [MAX_WINDOW];

  always_comb begin
    if (window_size == '0) begin
      w_eff = WIN_W'(1);
    end else if (CMP_W'(window_size) > CMP_W'(MAX_WINDOW)) begin
      w_eff = WIN_W'(MAX_WINDOW);
    end else begin
      w_eff = WIN_W'(window_size);
    end
  end

  assign w_last = IDX_W'(w_eff - WIN_W'(1));
  assign mid    = w_last >> 1;

  assign samples.ready = (state == swm_pkg::ST_IDLE);
  assign medians.valid = (state == swm_pkg::ST_DRAIN) && (cnt == '0);
  assign medians.median_value = pipes[0];

  assign ctl.accept = samples.valid && samples.ready;
  assign ctl.evict  = fill >= w_eff;
  assign has_result = ctl.evict || ((fill + WIN_W'(1)) >= w_eff);
  assign ctl.load   = ctl.accept && has_result;
  assign ctl.shift  = (state == swm_pkg::ST_DRAIN) && (cnt != '0);

  always_comb begin
    state_next = state;
    unique case (state)
      swm_pkg::ST_IDLE: begin
        if (ctl.load) state_next = swm_pkg::ST_DRAIN;
      end
      swm_pkg::ST_DRAIN: begin
        if (medians.valid && medians.ready) state_next = swm_pkg::ST_IDLE;
      end
    endcase
    if (cfg_wr_en) state_next = swm_pkg::ST_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= swm_pkg::ST_IDLE;
      window_size <= swm_pkg::WINDOW_RESET;
      fill        <= '0;
      cnt         <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        window_size <= cfg_wr_data;
        fill        <= '0;
      end else if (ctl.accept && !ctl.evict) begin
        fill <= fill + WIN_W'(1);
      end
      if (ctl.load) begin
        cnt <= mid;
      end else if (ctl.shift) begin
        cnt <= cnt - IDX_W'(1);
      end
    end
  end

  genvar i;
  generate
    for (i = 0; i < MAX_WINDOW; i++) begin : g_cell
      swm_pkg::nbr_t                  left_nbr, right_nbr;
      logic signed [SAMPLE_WIDTH-1:0] left_value, right_value, right_tap, right_pipe;

      if (i == 0) begin : g_first
        assign left_nbr   = '{ge: 1'b0, le: 1'b0, lep: 1'b1};
        assign left_value = samples.sample;
      end else begin : g_inner_left
        assign left_nbr   = nbrs[i-1];
        assign left_value = vals[i-1];
      end

      if (i == MAX_WINDOW-1) begin : g_last
        assign right_nbr   = '0;
        assign right_value = samples.sample;
        assign right_tap   = samples.sample;
        assign right_pipe  = '0;
      end else begin : g_inner_right
        assign right_nbr   = nbrs[i+1];
        assign right_value = vals[i+1];
        assign right_tap   = taps[i+1];
        assign right_pipe  = pipes[i+1];
      end

      swm_cell #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .MAX_WINDOW   (MAX_WINDOW),
        .INDEX        (i)
      ) u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .x           (samples.sample),
        .old         (taps[0]),
        .fill        (fill),
        .w_last      (w_last),
        .left_nbr    (left_nbr),
        .left_value  (left_value),
        .right_nbr   (right_nbr),
        .right_value (right_value),
        .right_tap   (right_tap),
        .right_pipe  (right_pipe),
        .nbr         (nbrs[i]),
        .value       (vals[i]),
        .tap         (taps[i]),
        .pipe        (pipes[i])
      );
    end
  endgenerate

endmodule

// ===== hw/rtl/swm_checker.sv =====
// Port-level checks of the median filter, bound to the top level.
`include "sliding_window_median_top_macros.svh"

module swm_checker #(
  parameter int SAMPLE_WIDTH = swm_pkg::DEF_SAMPLE_WIDTH
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           cfg_wr_en,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic signed [SAMPLE_WIDTH-1:0] out_data
);

  // A pending result holds until taken, unless a window write drops it.
  `SWM_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready && !cfg_wr_en, out_valid && $stable(out_data), "median transaction dropped or changed while stalled")

  // Only one sample in flight: no new transaction while a result waits.
  `SWM_ASSERT_NOW(a_one_in_flight, clk, rst, out_valid, !in_ready, "sample accepted while a median is pending")

  // A window write empties the window, so nothing is offered right after.
  `SWM_ASSERT_NEXT(a_cfg_clears, clk, rst, cfg_wr_en, !out_valid, "median offered right after a window write")

  `SWM_ASSERT_NEXT_ANY(a_reset_quiet, clk, rst, !out_valid, "median offered right after reset")

endmodule

bind sliding_window_median_top swm_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_swm_checker (
  .clk       (clk),
  .rst       (rst),
  .cfg_wr_en (cfg_wr_en),
  .in_ready  (samples.ready),
  .out_valid (medians.valid),
  .out_ready (medians.ready),
  .out_data  (medians.median_value)
);
